[hw/rtl/bba_pkg.sv]
// Shared types, codes and defaults for the bitmap block allocator.
// No dependencies; the interfaces, sequencer, datapath and top level use it.
package bba_pkg;

  localparam int NumBlocksDef   = 1024;
  localparam int BlockBytesDef  = 1024;
  localparam int MaxFilesDef    = 64;
  localparam int MaxBlocksDef   = 16;
  localparam int WordW          = 32;  // bitmap bits per memory row
  localparam int PosW           = 5;   // bit position inside a row

  localparam int ReqTypeW = 2;
  localparam int FileIdW  = 6;
  localparam int SizeW    = 15;
  localparam int StatusW  = 3;
  localparam int BlkOutW  = 10;

  localparam logic [ReqTypeW-1:0] REQ_CREATE = 2'd0;
  localparam logic [ReqTypeW-1:0] REQ_DELETE = 2'd1;
  localparam logic [ReqTypeW-1:0] REQ_LIST   = 2'd2;

  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_EXISTS    = 3'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd3;
  localparam logic [StatusW-1:0] ST_TOO_LARGE = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_SIZE,
    OP_ROW_LOAD,
    OP_TAKE,
    OP_ROW_WB,
    OP_CREATE_FIN,
    OP_BLK_LOAD,
    OP_FREE_BIT,
    OP_DEL_FIN,
    OP_EMIT,
    OP_EMIT_BLK
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [StatusW-1:0]  st;
  } cmd_t;

  typedef struct packed {
    logic                req_valid;
    logic [ReqTypeW-1:0] req_type;
    logic                clear_done;
    logic                size_busy;
    logic                bad_id;
    logic                exists;
    logic                too_large;
    logic                full;
    logic                row_full;
    logic                need_done;
    logic                list_done;
    logic                n_zero;
    logic                out_free;
  } stat_t;

endpackage

[hw/rtl/bba_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on bba_pkg for field widths.
interface bba_req_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::ReqTypeW-1:0] req_type;
  logic [bba_pkg::FileIdW-1:0]  file_id;
  logic [bba_pkg::SizeW-1:0]    size_bytes;

  modport source (output valid, req_type, file_id, size_bytes, input ready);
  modport sink (input valid, req_type, file_id, size_bytes, output ready);
endinterface

interface bba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::StatusW-1:0] status;
  logic [bba_pkg::BlkOutW-1:0] blk_no;
  logic                        block_valid;
  logic                        last;

  modport source (output valid, status, blk_no, block_valid, last, input ready);
  modport sink (input valid, status, blk_no, block_valid, last, output ready);
endinterface

[hw/rtl/bba_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bba_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/bba_ctrl.sv]
// Sequencer for the allocator: walks each request through the datapath.
// Depends on bba_pkg (cmd_t, stat_t, codes).
module bba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  bba_pkg::stat_t stat,
  output bba_pkg::cmd_t  cmd,
  output logic           ready
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SIZE, S_CHECK,
    S_C_RD, S_C_LOAD, S_C_TAKE, S_C_FIN,
    S_D_CHK, S_D_LRD, S_D_BRD, S_D_FREE, S_D_FIN,
    S_L_CHK, S_L_RD, S_L_OUT, S_EMIT
  } state_t;

  state_t             state, state_next;
  logic [StatusW-1:0] st, st_next;

  assign ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    st_next    = st;
    cmd.op     = OP_NONE;
    cmd.st     = st;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (stat.req_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.req_type) inside
          REQ_CREATE: begin
            if (stat.bad_id) begin
              st_next = ST_NOT_FOUND; state_next = S_EMIT;
            end else if (stat.exists) begin
              st_next = ST_EXISTS; state_next = S_EMIT;
            end else begin
              state_next = S_SIZE;
            end
          end
          REQ_DELETE, REQ_LIST: begin
            if (stat.bad_id || !stat.exists) begin
              st_next = ST_NOT_FOUND; state_next = S_EMIT;
            end else begin
              st_next    = ST_OK;
              state_next = (stat.req_type == REQ_DELETE) ? S_D_CHK : S_L_CHK;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SIZE: begin
        if (stat.size_busy) cmd.op = OP_SIZE;
        else state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.too_large) begin
          st_next = ST_TOO_LARGE; state_next = S_EMIT;
        end else if (stat.full) begin
          st_next = ST_FULL; state_next = S_EMIT;
        end else if (stat.need_done) begin
          state_next = S_C_FIN;
        end else begin
          state_next = S_C_RD;
        end
      end
      S_C_RD:   state_next = S_C_LOAD;
      S_C_LOAD: begin
        cmd.op     = OP_ROW_LOAD;
        state_next = S_C_TAKE;
      end
      S_C_TAKE: begin
        if (stat.need_done || stat.row_full) begin
          cmd.op     = OP_ROW_WB;
          state_next = stat.need_done ? S_C_FIN : S_C_RD;
        end else begin
          cmd.op = OP_TAKE;
        end
      end
      S_C_FIN: begin
        cmd.op     = OP_CREATE_FIN;
        st_next    = ST_OK;
        state_next = S_EMIT;
      end
      S_D_CHK:  state_next = stat.list_done ? S_D_FIN : S_D_LRD;
      S_D_LRD:  state_next = S_D_BRD;
      S_D_BRD: begin
        cmd.op     = OP_BLK_LOAD;
        state_next = S_D_FREE;
      end
      S_D_FREE: begin
        cmd.op     = OP_FREE_BIT;
        state_next = S_D_CHK;
      end
      S_D_FIN: begin
        cmd.op     = OP_DEL_FIN;
        state_next = S_EMIT;
      end
      S_L_CHK: begin
        if (stat.n_zero) state_next = S_EMIT;
        else if (stat.list_done) state_next = S_IDLE;
        else state_next = S_L_RD;
      end
      S_L_RD: state_next = S_L_OUT;
      S_L_OUT: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT_BLK;
          state_next = S_L_CHK;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      st    <= ST_OK;
    end else begin
      state <= state_next;
      st    <= st_next;
    end
  end

  property p_no_accept_busy;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> (cmd.op != OP_ACCEPT);
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  property p_clear_first;
    @(posedge clk) $past(rst) |-> (state == S_CLEAR);
  endproperty
  a_clear_first: assert property (p_clear_first) else $error("no clear after reset");

  property p_emit_leads_idle;
    @(posedge clk) disable iff (rst) (cmd.op == OP_EMIT) |=> (state == S_IDLE);
  endproperty
  a_emit_leads_idle: assert property (p_emit_leads_idle) else $error("emit did not end");
endmodule

[hw/rtl/bba_dp.sv]
// Allocator datapath: bitmap, directory, block lists, free count, result register.
// Depends on bba_pkg and bba_ram.
module bba_dp #(
  parameter int TOTAL_BLOCKS        = bba_pkg::NumBlocksDef,
  parameter int BLOCK_BYTES         = bba_pkg::BlockBytesDef,
  parameter int MAX_FILES           = bba_pkg::MaxFilesDef,
  parameter int MAX_BLOCKS_PER_FILE = bba_pkg::MaxBlocksDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bba_pkg::cmd_t                cmd,
  output bba_pkg::stat_t               stat,
  input  logic                         req_valid,
  input  logic [bba_pkg::ReqTypeW-1:0] req_rtype,
  input  logic [bba_pkg::FileIdW-1:0]  req_fid,
  input  logic [bba_pkg::SizeW-1:0]    req_size,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [bba_pkg::StatusW-1:0]  rsp_status,
  output logic [bba_pkg::BlkOutW-1:0]  rsp_blk_no,
  output logic                         rsp_blk_valid,
  output logic                         rsp_last
);
  import bba_pkg::*;

  localparam int BLK_W   = $clog2(TOTAL_BLOCKS);
  localparam int ROWS    = (TOTAL_BLOCKS + WordW - 1) / WordW;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FREE_W  = $clog2(TOTAL_BLOCKS + 1);
  localparam int SLOT_W  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int CNT_W   = $clog2(MAX_BLOCKS_PER_FILE + 1);
  localparam int NEED_W  = $clog2(MAX_BLOCKS_PER_FILE + 2);
  localparam int ACC_W   = $clog2((MAX_BLOCKS_PER_FILE + 1) * BLOCK_BYTES + 32768);
  localparam int LIST_D  = MAX_FILES * MAX_BLOCKS_PER_FILE;
  localparam int LIST_AW = (LIST_D > 1) ? $clog2(LIST_D) : 1;

  logic [ReqTypeW-1:0] req_type;
  logic [FileIdW-1:0]  id;
  logic [SizeW-1:0]    size;
  logic [SLOT_W-1:0]   slot;
  logic [ACC_W-1:0]    acc;
  logic [NEED_W-1:0]   need;
  logic [CNT_W-1:0]    idx;
  logic [ROW_W-1:0]    row;
  logic [ROW_W-1:0]    clr_row;
  logic [WordW-1:0]    rowbuf;
  logic [BLK_W-1:0]    blk;
  logic [FREE_W-1:0]   free_blocks;
  logic [MAX_FILES-1:0] in_use;

  // memory ports
  logic              bm_we;
  logic [ROW_W-1:0]  bm_waddr, bm_raddr;
  logic [WordW-1:0]  bm_wdata, bm_rdata;
  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_rdata;
  logic              lst_we;
  logic [LIST_AW-1:0] lst_addr;
  logic [BLK_W-1:0]  lst_rdata;

  logic [PosW-1:0]   pos;
  logic [BLK_W-1:0]  take_blk;
  logic [WordW-1:0]  clr_word;
  logic [PosW-1:0]   free_pos;

  assign slot     = SLOT_W'(id);
  assign lst_addr = LIST_AW'(32'(slot) * MAX_BLOCKS_PER_FILE + 32'(idx));

  // lowest clear bit of the row under allocation
  always_comb begin
    pos = '0;
    for (int j = WordW - 1; j >= 0; j--) begin
      if (!rowbuf[j]) pos = PosW'(j);
    end
  end
  assign take_blk = BLK_W'({row, pos});

  // bits past the last block read as taken
  always_comb begin
    for (int j = 0; j < WordW; j++) begin
      clr_word[j] = (32'(clr_row) * WordW + j) >= TOTAL_BLOCKS;
    end
  end

  assign free_pos = PosW'(blk);

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = row;
    bm_wdata = rowbuf;
    bm_raddr = row;
    unique case (cmd.op)
      OP_CLEAR: begin
        bm_we = 1'b1; bm_waddr = clr_row; bm_wdata = clr_word;
      end
      OP_ROW_WB: bm_we = 1'b1;
      OP_BLK_LOAD: bm_raddr = ROW_W'(lst_rdata >> PosW);
      OP_FREE_BIT: begin
        bm_we    = 1'b1;
        bm_waddr = ROW_W'(blk >> PosW);
        bm_wdata = bm_rdata & ~(WordW'(1) << free_pos);
      end
      default: ;
    endcase
  end

  assign cnt_we = (cmd.op == OP_CREATE_FIN);
  assign lst_we = (cmd.op == OP_TAKE);

  bba_ram #(.W(WordW), .D(ROWS)) u_bitmap (
    .clk, .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  bba_ram #(.W(CNT_W), .D(MAX_FILES)) u_count (
    .clk, .we(cnt_we), .waddr(slot), .wdata(CNT_W'(need)),
    .raddr(slot), .rdata(cnt_rdata)
  );

  bba_ram #(.W(BLK_W), .D(LIST_D)) u_list (
    .clk, .we(lst_we), .waddr(lst_addr), .wdata(take_blk),
    .raddr(lst_addr), .rdata(lst_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row     <= '0;
      free_blocks <= FREE_W'(TOTAL_BLOCKS);
      in_use      <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_ready) rsp_valid <= 1'b0;
      unique case (cmd.op)
        OP_CLEAR: clr_row <= clr_row + ROW_W'(1);
        OP_ACCEPT: begin
          req_type <= req_rtype;
          id       <= req_fid;
          size     <= req_size;
          acc      <= '0;
          need     <= '0;
          idx      <= '0;
          row      <= '0;
        end
        OP_SIZE: begin
          acc  <= acc + ACC_W'(BLOCK_BYTES);
          need <= need + NEED_W'(1);
        end
        OP_ROW_LOAD: rowbuf <= bm_rdata;
        OP_TAKE: begin
          rowbuf[pos] <= 1'b1;
          idx         <= idx + CNT_W'(1);
          free_blocks <= free_blocks - FREE_W'(1);
        end
        OP_ROW_WB: row <= row + ROW_W'(1);
        OP_CREATE_FIN: in_use[slot] <= 1'b1;
        OP_BLK_LOAD: blk <= lst_rdata;
        OP_FREE_BIT: begin
          idx         <= idx + CNT_W'(1);
          free_blocks <= free_blocks + FREE_W'(1);
        end
        OP_DEL_FIN: in_use[slot] <= 1'b0;
        OP_EMIT: begin
          rsp_valid     <= 1'b1;
          rsp_status    <= cmd.st;
          rsp_blk_no    <= '0;
          rsp_blk_valid <= 1'b0;
          rsp_last      <= 1'b1;
        end
        OP_EMIT_BLK: begin
          rsp_valid     <= 1'b1;
          rsp_status    <= ST_OK;
          rsp_blk_no    <= BlkOutW'(lst_rdata);
          rsp_blk_valid <= 1'b1;
          rsp_last      <= (idx + CNT_W'(1)) == cnt_rdata;
          idx           <= idx + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.req_valid  = req_valid;
    stat.req_type   = req_type;
    stat.clear_done = (32'(clr_row) == ROWS - 1);
    stat.size_busy  = (32'(acc) < 32'(size)) && (32'(need) <= MAX_BLOCKS_PER_FILE);
    stat.bad_id     = 32'(id) >= MAX_FILES;
    stat.exists     = in_use[slot];
    stat.too_large  = 32'(need) > MAX_BLOCKS_PER_FILE;
    stat.full       = 32'(need) > 32'(free_blocks);
    stat.row_full   = &rowbuf;
    stat.need_done  = 32'(idx) == 32'(need);
    stat.list_done  = idx == cnt_rdata;
    stat.n_zero     = (cnt_rdata == '0);
    stat.out_free   = !rsp_valid || rsp_ready;
  end

  property p_free_bound;
    @(posedge clk) disable iff (rst) 32'(free_blocks) <= TOTAL_BLOCKS;
  endproperty
  a_free_bound: assert property (p_free_bound) else $error("free count overflow");

  property p_emit_room;
    @(posedge clk) disable iff (rst)
      (cmd.op == OP_EMIT || cmd.op == OP_EMIT_BLK) |-> stat.out_free;
  endproperty
  a_emit_room: assert property (p_emit_room) else $error("result overwritten");

  property p_take_has_room;
    @(posedge clk) disable iff (rst) (cmd.op == OP_TAKE) |-> !(&rowbuf);
  endproperty
  a_take_has_room: assert property (p_take_has_room) else $error("take from full row");

  property p_free_used;
    @(posedge clk) disable iff (rst) (cmd.op == OP_FREE_BIT) |-> bm_rdata[free_pos];
  endproperty
  a_free_used: assert property (p_free_used) else $error("freeing a free block");
endmodule

[hw/rtl/bitmap_block_allocator.sv]
// Bitmap block allocator top level: sequencer plus datapath.
// Depends on bba_pkg, bba_if, bba_ram, bba_ctrl, bba_dp.
//
// Usage: requests arrive on req (create, delete, list of a file slot);
// results leave on rsp, one per create or delete, one per block for a
// list (or one with block_valid low for an empty or unknown file), last on the final.
// One request is handled at a time; req.ready is high only when idle.
// Steps per request, as the sequencer walks the memories:
//   create: one size step per block needed, then per bitmap row visited a
//           read, a row load, one take per block taken and a write-back.
//   delete: per block of the file, a list read, a block load and a bit free.
//   list:   per block of the file, a list read and an output of the block.
// Results sit in an output register; a stalled rsp holds the sequencer
// until the pending result is taken, nothing is dropped.
// Reset: free count restored, directory emptied, then a clearing pass over
// every bitmap row wipes the bitmap, with req.ready low throughout.
module bitmap_block_allocator #(
  parameter int TOTAL_BLOCKS        = bba_pkg::NumBlocksDef,
  parameter int BLOCK_BYTES         = bba_pkg::BlockBytesDef,
  parameter int MAX_FILES           = bba_pkg::MaxFilesDef,
  parameter int MAX_BLOCKS_PER_FILE = bba_pkg::MaxBlocksDef
) (
  input logic       clk,
  input logic       rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);
  import bba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bba_ctrl u_ctrl (
    .clk, .rst, .stat(stat), .cmd(cmd), .ready(req.ready)
  );

  bba_dp #(
    .TOTAL_BLOCKS(TOTAL_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES),
    .MAX_FILES(MAX_FILES), .MAX_BLOCKS_PER_FILE(MAX_BLOCKS_PER_FILE)
  ) u_dp (
    .clk, .rst, .cmd(cmd), .stat(stat),
    .req_valid(req.valid), .req_rtype(req.req_type),
    .req_fid(req.file_id), .req_size(req.size_bytes),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.status), .rsp_blk_no(rsp.blk_no),
    .rsp_blk_valid(rsp.block_valid), .rsp_last(rsp.last)
  );
endmodule
